FILE: rtl/jtl_pkg.sv
`default_nettype none
package jtl_pkg;

   // lexer mode between items
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_SKIP   = 2'd3
   } mode_type;

   // token kinds
   localparam logic [3:0] TK_LBRACE   = 4'd0;
   localparam logic [3:0] TK_RBRACE   = 4'd1;
   localparam logic [3:0] TK_COLON    = 4'd2;
   localparam logic [3:0] TK_COMMA    = 4'd3;
   localparam logic [3:0] TK_LBRACKET = 4'd4;
   localparam logic [3:0] TK_RBRACKET = 4'd5;
   localparam logic [3:0] TK_STRING   = 4'd6;
   localparam logic [3:0] TK_NUMBER   = 4'd7;
   localparam logic [3:0] TK_BOOLEAN  = 4'd8;
   localparam logic [3:0] TK_NULL     = 4'd9;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_OPEN_STRING = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED  = 2'd2;

   // characters
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_T        = 8'h74;
   localparam logic [7:0] CH_F        = 8'h66;
   localparam logic [7:0] CH_N        = 8'h6E;

   // letters skipped after the leading letter of a literal
   localparam logic [2:0] SKIP_TRUE_NULL = 3'd3;
   localparam logic [2:0] SKIP_FALSE     = 3'd4;

   // output queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [3:0] token_type;
      logic [7:0] value_byte;
      logic       has_byte;
      logic       token_end;
      logic [1:0] error_code;
   } token_item_type;

   typedef struct packed {
      token_item_type item;
      logic           run_last;
   } queue_entry_type;

   typedef struct packed {
      logic           valid;
      token_item_type item;
      mode_type       mode;
      logic [2:0]     skip;
   } idle_result_type;

   function automatic token_item_type make_item(input logic [3:0] kind,
                                                input logic [7:0] value,
                                                input logic has, input logic last,
                                                input logic [1:0] err);
      token_item_type t;
      t.token_type = kind;
      t.value_byte = value;
      t.has_byte   = has;
      t.token_end  = last;
      t.error_code = err;
      return t;
   endfunction

   // handle one byte while between tokens
   function automatic idle_result_type idle_byte(input logic [7:0] c);
      idle_result_type r;
      r.valid = 1'b1;
      r.item  = make_item(TK_LBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
      r.mode  = MODE_IDLE;
      r.skip  = 3'd0;
      unique case (c)
         CH_SPACE, CH_NEWLINE: r.valid = 1'b0;
         CH_QUOTE: begin
            r.valid = 1'b0;
            r.mode  = MODE_STRING;
         end
         CH_LBRACE:   r.item.token_type = TK_LBRACE;
         CH_RBRACE:   r.item.token_type = TK_RBRACE;
         CH_COLON:    r.item.token_type = TK_COLON;
         CH_COMMA:    r.item.token_type = TK_COMMA;
         CH_LBRACKET: r.item.token_type = TK_LBRACKET;
         CH_RBRACKET: r.item.token_type = TK_RBRACKET;
         CH_T: begin
            r.item = make_item(TK_BOOLEAN, 8'd1, 1'b1, 1'b1, ERR_NONE);
            r.mode = MODE_SKIP;
            r.skip = SKIP_TRUE_NULL;
         end
         CH_F: begin
            r.item = make_item(TK_BOOLEAN, 8'd0, 1'b1, 1'b1, ERR_NONE);
            r.mode = MODE_SKIP;
            r.skip = SKIP_FALSE;
         end
         CH_N: begin
            r.item = make_item(TK_NULL, 8'd0, 1'b0, 1'b1, ERR_NONE);
            r.mode = MODE_SKIP;
            r.skip = SKIP_TRUE_NULL;
         end
         default: begin
            if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
               r.item = make_item(TK_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
               r.mode = MODE_NUMBER;
            end else begin
               r.item = make_item(TK_LBRACE, 8'd0, 1'b0, 1'b0, ERR_UNEXPECTED);
            end
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/json_token_lexer_top.sv
// Results go into a registered four-entry output queue and leave from its head on rsp_.
// Throughput: one input item per cycle while each makes at most one result item and
// rsp_tready is high; req_tready drops while the queue holds more than two entries, and the
// results of an item that makes two leave one at a time through the queue's single read port.
// Reset: synchronous, active high; lexer returns to idle between tokens, queue empties.
`default_nettype none
module json_token_lexer_top import jtl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tuser,   // [0] end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] value_byte, [8] has_byte,
                                         // [9] token_end, [11:10] error_code, [15:12] zero
   output logic [3:0]       rsp_tuser,   // [3:0] token_type
   output logic             rsp_tlast    // run_last
);

   mode_type        mode_ff, mode_in;
   logic [2:0]      skip_ff, skip_in;
   queue_entry_type queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   token_item_type  res0, res1;
   logic [1:0]      n_res;
   idle_result_type idle_r;
   logic            accept, pop;
   logic [7:0]      c;
   logic            is_num;

   assign c      = req_tdata;
   assign is_num = (c == CH_MINUS) || (c == CH_DOT) || (c >= CH_ZERO && c <= CH_NINE);
   assign idle_r = idle_byte(c);

   // accept only with room for two results
   assign req_tready = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   // decode one item into up to two results and the next mode
   always_comb begin
      res0    = make_item(TK_LBRACE, 8'd0, 1'b0, 1'b0, ERR_NONE);
      res1    = res0;
      n_res   = 2'd0;
      mode_in = mode_ff;
      skip_in = skip_ff;
      if (req_tuser) begin
         mode_in = MODE_IDLE;
         skip_in = 3'd0;
         if (mode_ff == MODE_STRING) begin
            res0  = make_item(TK_STRING, 8'd0, 1'b0, 1'b1, ERR_OPEN_STRING);
            n_res = 2'd1;
         end else if (mode_ff == MODE_NUMBER) begin
            res0  = make_item(TK_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
            n_res = 2'd1;
         end
      end else begin
         unique case (mode_ff)
            MODE_STRING: begin
               n_res = 2'd1;
               if (c == CH_QUOTE) begin
                  res0    = make_item(TK_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
                  mode_in = MODE_IDLE;
               end else begin
                  res0 = make_item(TK_STRING, c, 1'b1, 1'b0, ERR_NONE);
               end
            end
            MODE_NUMBER: begin
               if (is_num) begin
                  res0  = make_item(TK_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
                  n_res = 2'd1;
               end else begin
                  // close the number, then handle the byte afresh
                  res0    = make_item(TK_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
                  res1    = idle_r.item;
                  n_res   = idle_r.valid ? 2'd2 : 2'd1;
                  mode_in = idle_r.mode;
                  skip_in = idle_r.skip;
               end
            end
            MODE_SKIP: begin
               if (skip_ff != 3'd0) begin
                  skip_in = skip_ff - 3'd1;
                  if (skip_ff == 3'd1) begin
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  res0    = idle_r.item;
                  n_res   = {1'b0, idle_r.valid};
                  mode_in = idle_r.mode;
                  skip_in = idle_r.skip;
               end
            end
            MODE_IDLE: begin
               res0    = idle_r.item;
               n_res   = {1'b0, idle_r.valid};
               mode_in = idle_r.mode;
               skip_in = idle_r.skip;
            end
         endcase
      end
   end

   // advance queue occupancy
   assign count_in = count_ff + (accept ? {1'b0, n_res} : '0) - {{QUEUE_AW{1'b0}}, pop};

   // hold lexer state and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         skip_ff   <= 3'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            skip_ff   <= skip_in;
            wr_ptr_ff <= wr_ptr_ff + n_res[QUEUE_AW-1:0];
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   // write results into the queue
   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= '{item: res0, run_last: (n_res == 2'd1)};
      end
      if (accept && n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + QUEUE_AW'(1)] <= '{item: res1, run_last: 1'b1};
      end
   end

   // drive the result channel from the queue head
   queue_entry_type head;
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {4'd0, head.item.error_code, head.item.token_end,
                       head.item.has_byte, head.item.value_byte};
   assign rsp_tuser = head.item.token_type;
   assign rsp_tlast = head.run_last;

   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("output queue overflow");

   // skip counter is live exactly in skip mode
   a_skip_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SKIP) == (skip_ff != 3'd0))
      else $error("skip counter out of step with mode");

   // a pop with no accept drops the count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !accept) |=> (count_ff == $past(count_ff) - (QUEUE_AW+1)'(1)))
      else $error("queue count not decremented");

   // an accepted item that makes two results leaves two more in the queue
   a_two_results: assert property (@(posedge clock) disable iff (reset)
      (accept && n_res == 2'd2 && !pop) |=> (count_ff == $past(count_ff) + (QUEUE_AW+1)'(2)))
      else $error("second result lost");

endmodule
`default_nettype wire
